FILE: design/bcc_pkg.sv
`default_nettype none

package bcc_pkg;

    localparam int unsigned TAG_W    = 32;
    localparam int unsigned SLOT_W   = 5;
    localparam int unsigned MAX_OUT  = 32;
    localparam int unsigned CNT_W    = $clog2(MAX_OUT + 1);

    // Request codes on i_opcode
    typedef enum logic [1:0] {
        OP_GET   = 2'd0,
        OP_MARK  = 2'd1,
        OP_FLUSH = 2'd2
    } t_opcode;

    // Result codes on o_status
    typedef enum logic [2:0] {
        STS_HIT        = 3'd0,
        STS_FILL       = 3'd1,
        STS_NO_SLOT    = 3'd2,
        STS_MARKED     = 3'd3,
        STS_NOT_PRESENT = 3'd4,
        STS_WRITEBACK  = 3'd5,
        STS_FLUSH_DONE = 3'd6
    } t_status;

    // One slot's tag and flags as held by a cell
    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [TAG_W-1:0] tag;
    } t_entry;

endpackage

`default_nettype wire

FILE: design/block_cache_tag_controller_core.sv
`default_nettype none

// Tag controller for a fully associative write-back cache of disk blocks.
// A request is taken when start is high and busy is low; results leave on
// o_valid, one cycle each, and cannot be held off by the receiver, so it
// must take every result in the cycle it is shown. The slot tags and flags
// sit in a ring of NUM_SLOTS cells that, during the scan, rotates one place
// per cycle past a single compare head; each request passes through one
// load, NUM_SLOTS scan steps and one finish step, and busy stays high
// through the scan and finish steps. An unused opcode is taken without
// leaving idle and gives no result. Get and mark-dirty give one result in the
// finish step. A flush gives its writebacks during the scan, at most one a
// cycle, each one held back a step so that the final one can carry o_last;
// the final writeback, or a flush-done when nothing was dirty, appears in
// the finish step. At most 32 writebacks come from one flush; any further
// dirty slots stay dirty for the next flush.

module block_cache_tag_controller_core #(
    parameter int unsigned NUM_SLOTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_block_id,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [4:0]  o_slot,
    output logic [31:0] o_sector,
    output logic        o_last
);
    import bcc_pkg::*;

    localparam int unsigned SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state           r_state;
    logic [1:0]       r_op;
    logic [TAG_W-1:0] r_id;
    logic [SW-1:0]    r_step;
    logic             r_hit;
    logic [SW-1:0]    r_hit_slot;
    logic             r_free_found;
    logic [SW-1:0]    r_free_slot;
    logic [CNT_W-1:0] r_wb_cnt;
    logic             r_pend;
    logic [SW-1:0]    r_pend_slot;
    logic [TAG_W-1:0] r_pend_tag;

    logic             r_out_vld;
    t_status          r_status;
    logic [SW-1:0]    r_out_slot;
    logic [TAG_W-1:0] r_sector;
    logic             r_last;

    t_entry           w_cell [NUM_SLOTS];
    t_entry           w_head;
    t_entry           w_ret;
    t_entry           w_fill;
    logic             w_shift;
    logic             w_match;
    logic             w_free;
    logic             w_wb;
    logic             w_mark;
    logic             w_do_fill;

    assign busy    = (r_state != S_IDLE);
    assign w_shift = (r_state == S_SCAN);
    assign w_head  = w_cell[0];

    // Head compare: the cell at place 0 holds slot r_step during the scan
    assign w_match = w_head.valid && (w_head.tag == r_id);
    assign w_free  = !w_head.valid || !w_head.dirty;
    assign w_mark  = (r_op == OP_MARK) && w_match && !r_hit;
    assign w_wb    = (r_op == OP_FLUSH) && w_head.valid && w_head.dirty
                     && (r_wb_cnt < CNT_W'(MAX_OUT));

    // Set or clear the dirty flag as the entry goes back round the ring
    always_comb begin
        w_ret = w_head;
        if (w_mark) begin
            w_ret.dirty = 1'b1;
        end else if (w_wb) begin
            w_ret.dirty = 1'b0;
        end
    end

    assign w_do_fill = (r_state == S_FINISH) && (r_op == OP_GET) && !r_hit
                       && r_free_found;
    assign w_fill    = '{valid: 1'b1, dirty: 1'b0, tag: r_id};

    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_ring
        t_entry w_next;

        if (k == NUM_SLOTS - 1) begin : g_tail
            assign w_next = w_ret;
        end else begin : g_mid
            assign w_next = w_cell[k+1];
        end

        bcc_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_shift   (w_shift),
            .i_wr      (w_do_fill && (r_free_slot == SW'(k))),
            .i_next    (w_next),
            .i_wr_data (w_fill),
            .o_entry   (w_cell[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_vld    <= 1'b0;
            r_op         <= OP_GET;
            r_id         <= '0;
            r_step       <= '0;
            r_hit        <= 1'b0;
            r_hit_slot   <= '0;
            r_free_found <= 1'b0;
            r_free_slot  <= '0;
            r_wb_cnt     <= '0;
            r_pend       <= 1'b0;
            r_pend_slot  <= '0;
            r_pend_tag   <= '0;
            r_status     <= STS_HIT;
            r_out_slot   <= '0;
            r_sector     <= '0;
            r_last       <= 1'b0;
        end else begin
            r_out_vld <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    // Drop the unused opcode without leaving idle
                    if (start && (i_opcode == OP_GET || i_opcode == OP_MARK
                                  || i_opcode == OP_FLUSH)) begin
                        r_op         <= i_opcode;
                        r_id         <= i_block_id;
                        r_step       <= '0;
                        r_hit        <= 1'b0;
                        r_free_found <= 1'b0;
                        r_wb_cnt     <= '0;
                        r_pend       <= 1'b0;
                        r_state      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_op != OP_FLUSH && w_match && !r_hit) begin
                        r_hit      <= 1'b1;
                        r_hit_slot <= r_step;
                    end
                    if (r_op == OP_GET && w_free && !r_free_found) begin
                        r_free_found <= 1'b1;
                        r_free_slot  <= r_step;
                    end
                    if (w_wb) begin
                        // Release the held writeback, hold the new one
                        r_wb_cnt    <= r_wb_cnt + CNT_W'(1);
                        r_pend      <= 1'b1;
                        r_pend_slot <= r_step;
                        r_pend_tag  <= w_head.tag;
                        if (r_pend) begin
                            r_out_vld  <= 1'b1;
                            r_status   <= STS_WRITEBACK;
                            r_out_slot <= r_pend_slot;
                            r_sector   <= r_pend_tag;
                            r_last     <= 1'b0;
                        end
                    end
                    if (r_step == SW'(NUM_SLOTS - 1)) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_step <= r_step + SW'(1);
                    end
                end
                S_FINISH: begin
                    r_out_vld  <= 1'b1;
                    r_last     <= 1'b1;
                    r_out_slot <= '0;
                    r_sector   <= '0;
                    case (r_op)
                        OP_GET: begin
                            if (r_hit) begin
                                r_status   <= STS_HIT;
                                r_out_slot <= r_hit_slot;
                            end else if (r_free_found) begin
                                r_status   <= STS_FILL;
                                r_out_slot <= r_free_slot;
                                r_sector   <= r_id;
                            end else begin
                                r_status <= STS_NO_SLOT;
                            end
                        end
                        OP_MARK: begin
                            if (r_hit) begin
                                r_status   <= STS_MARKED;
                                r_out_slot <= r_hit_slot;
                            end else begin
                                r_status <= STS_NOT_PRESENT;
                            end
                        end
                        default: begin
                            if (r_pend) begin
                                r_status   <= STS_WRITEBACK;
                                r_out_slot <= r_pend_slot;
                                r_sector   <= r_pend_tag;
                            end else begin
                                r_status <= STS_FLUSH_DONE;
                            end
                        end
                    endcase
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid  = r_out_vld;
    assign o_status = r_status;
    assign o_slot   = SLOT_W'(r_out_slot);
    assign o_sector = r_sector;
    assign o_last   = r_last;

endmodule

`default_nettype wire

FILE: design/bcc_cell.sv
`default_nettype none

module bcc_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  logic            i_wr,
    input  bcc_pkg::t_entry i_next,
    input  bcc_pkg::t_entry i_wr_data,
    output bcc_pkg::t_entry o_entry
);
    import bcc_pkg::*;

    logic             r_valid;
    logic             r_dirty;
    logic [TAG_W-1:0] r_tag;

    // Flags: clear on reset, load i_wr_data on a write, else take i_next on a shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_dirty <= 1'b0;
        end else if (i_wr) begin
            r_valid <= i_wr_data.valid;
            r_dirty <= i_wr_data.dirty;
        end else if (i_shift) begin
            r_valid <= i_next.valid;
            r_dirty <= i_next.dirty;
        end
    end

    // Tag is undefined until written
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_tag <= i_wr_data.tag;
        end else if (i_shift) begin
            r_tag <= i_next.tag;
        end
    end

    assign o_entry = '{valid: r_valid, dirty: r_dirty, tag: r_tag};

endmodule

`default_nettype wire

FILE: tb/tb_block_cache_tag_controller_core.sv
`timescale 1ns / 1ps

module tb_block_cache_tag_controller_core;
    import bcc_pkg::*;

    localparam int unsigned NUM_SLOTS  = 32;
    localparam logic [1:0]  OP_UNUSED  = 2'd3;   // spare code, dropped by the block
    localparam int unsigned STALL_LIMIT = 2000;  // cycles with no transfer at all
    localparam int unsigned DRAIN_CYCLES = 40;   // one full request plus margin
    localparam int unsigned POOL_SIZE  = 40;     // a little over the slot count
    localparam int unsigned PRINT_CAP  = 100;

    // One expected result, field for field as on the result ports
    typedef struct packed {
        t_status     status;
        logic [4:0]  slot;
        logic [31:0] sector;
        logic        last;
    } t_cache_result;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        start      = 1'b0;
    logic [1:0]  i_opcode   = OP_GET;
    logic [31:0] i_block_id = 32'd0;
    logic        busy;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [4:0]  o_slot;
    logic [31:0] o_sector;
    logic        o_last;

    // Shadow copy of the tag store
    logic [31:0]    shadow_tag   [NUM_SLOTS];
    logic           shadow_valid [NUM_SLOTS];
    logic           shadow_dirty [NUM_SLOTS];

    t_cache_result  pending_results[$];
    int unsigned    mismatch_count = 0;
    int unsigned    idle_cycles    = 0;
    bit             no_gaps        = 1'b0;
    logic [31:0]    id_pool [POOL_SIZE];

    block_cache_tag_controller_core #(
        .NUM_SLOTS(NUM_SLOTS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_opcode   (i_opcode),
        .i_block_id (i_block_id),
        .o_valid    (o_valid),
        .o_status   (o_status),
        .o_slot     (o_slot),
        .o_sector   (o_sector),
        .o_last     (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // Work out the results of one accepted request and update the shadow store.
    // Lookups only ever compare valid slots, so unwritten tags never matter.
    task automatic predict_cache_results(input logic [1:0] op, input logic [31:0] id);
        int            hit_slot;
        int            free_slot;
        int unsigned   wb_count;
        t_cache_result res;

        hit_slot  = -1;
        free_slot = -1;
        wb_count  = 0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            if (hit_slot < 0 && shadow_valid[s] && shadow_tag[s] == id) begin
                hit_slot = s;
            end
            if (free_slot < 0 && (!shadow_valid[s] || !shadow_dirty[s])) begin
                free_slot = s;
            end
        end

        res = '{status: STS_HIT, slot: 5'd0, sector: 32'd0, last: 1'b1};
        case (op)
            OP_GET: begin
                if (hit_slot >= 0) begin
                    res.status = STS_HIT;
                    res.slot   = hit_slot[4:0];
                end else if (free_slot >= 0) begin
                    // retag the first clean or empty slot, no writeback needed
                    shadow_tag[free_slot]   = id;
                    shadow_valid[free_slot] = 1'b1;
                    shadow_dirty[free_slot] = 1'b0;
                    res.status = STS_FILL;
                    res.slot   = free_slot[4:0];
                    res.sector = id;
                end else begin
                    res.status = STS_NO_SLOT;
                end
                pending_results.push_back(res);
            end
            OP_MARK: begin
                if (hit_slot >= 0) begin
                    shadow_dirty[hit_slot] = 1'b1;
                    res.status = STS_MARKED;
                    res.slot   = hit_slot[4:0];
                end else begin
                    res.status = STS_NOT_PRESENT;
                end
                pending_results.push_back(res);
            end
            OP_FLUSH: begin
                for (int s = 0; s < NUM_SLOTS && wb_count < MAX_OUT; s++) begin
                    if (shadow_valid[s] && shadow_dirty[s]) begin
                        shadow_dirty[s] = 1'b0;
                        res = '{status: STS_WRITEBACK, slot: s[4:0],
                                sector: shadow_tag[s], last: 1'b0};
                        pending_results.push_back(res);
                        wb_count++;
                    end
                end
                if (wb_count == 0) begin
                    res = '{status: STS_FLUSH_DONE, slot: 5'd0, sector: 32'd0, last: 1'b1};
                    pending_results.push_back(res);
                end else begin
                    // only the final writeback carries last
                    pending_results[pending_results.size() - 1].last = 1'b1;
                end
            end
            default: ;  // spare opcode: no results, no change of state
        endcase
    endtask

    // Present one request, hold it until the block takes it, then predict.
    // Leave start high afterwards so a back-to-back request needs no re-raise.
    task automatic send_request(input logic [1:0] op, input logic [31:0] id);
        int unsigned gap;

        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_opcode   <= op;
        i_block_id <= id;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        predict_cache_results(op, id);
    endtask

    // Take every strobed result and compare it with the oldest expectation
    always @(posedge i_clk) begin
        t_cache_result want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status=%0d slot=%0d sector=%h last=%b",
                                          o_status, o_slot, o_sector, o_last));
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status || o_slot !== want.slot ||
                    o_sector !== want.sector || o_last !== want.last) begin
                    report_mismatch($sformatf(
                        "got status=%0d slot=%0d sector=%h last=%b, want %s slot=%0d sector=%h last=%b",
                        o_status, o_slot, o_sector, o_last,
                        want.status.name(), want.slot, want.sector, want.last));
                end
            end
        end
    end

    // Watchdog: end the run if neither side transfers anything for too long
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_valid === 1'b1) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Hits, fills, marks, an empty flush, a real flush and the spare opcode
    task automatic test_lookup_basics();
        send_request(OP_FLUSH,  32'h1234_5678);  // nothing dirty yet: flush done
        send_request(OP_MARK,   32'h0000_0000);  // empty cache: not present
        send_request(OP_GET,    32'h0000_0000);  // fill slot 0
        send_request(OP_GET,    32'hFFFF_FFFF);  // slot 0 is clean, so it is retagged
        send_request(OP_GET,    32'hFFFF_FFFF);  // hit
        send_request(OP_MARK,   32'hFFFF_FFFF);  // marked
        send_request(OP_GET,    32'h0000_0000);  // slot 0 dirty: lands in slot 1
        send_request(OP_GET,    32'h0000_0000);  // hit in slot 1
        send_request(OP_MARK,   32'hA5A5_5A5A);  // not present
        send_request(OP_UNUSED, 32'h5A5A_A5A5);  // dropped
        send_request(OP_MARK,   32'h0000_0000);
        send_request(OP_FLUSH,  32'hFFFF_FFFF);  // two writebacks
        send_request(OP_FLUSH,  32'h0000_0000);  // clean again: flush done
    endtask

    // Fill and dirty every slot: no slot, then a full-width flush
    task automatic test_all_slots_dirty();
        for (int s = 0; s < NUM_SLOTS; s++) begin
            send_request(OP_GET,  32'hC0DE_0000 + s);
            send_request(OP_MARK, 32'hC0DE_0000 + s);
        end
        send_request(OP_GET,   32'h7FFF_FFFF);   // every slot dirty: no slot
        send_request(OP_MARK,  32'hC0DE_001F);   // already dirty, marked again
        send_request(OP_GET,   32'hC0DE_0010);   // hit while full
        send_request(OP_FLUSH, 32'h0000_0000);   // 32 writebacks
        send_request(OP_FLUSH, 32'h0000_0000);   // flush done
        send_request(OP_GET,   32'h8000_0000);   // back to slot 0
    endtask

    // Mostly requests on a small pool of block numbers so that hits, marks
    // and a full cache all occur; the rest is random numbers and noise.
    task automatic test_random_traffic(input int unsigned n_items);
        logic [31:0] recent_id;
        logic [31:0] id;
        int unsigned pick;

        recent_id = id_pool[0];
        for (int unsigned k = 0; k < n_items; k++) begin
            // alternate stretches with and without gaps
            no_gaps = ((k / 25) % 2) == 1;
            id = ($urandom_range(0, 99) < 80) ? id_pool[$urandom_range(0, POOL_SIZE - 1)]
                                              : $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                send_request(OP_GET, id);
                recent_id = id;
            end else if (pick < 85) begin
                send_request(OP_MARK, $urandom_range(0, 1) ? recent_id : id);
            end else if (pick < 94) begin
                send_request(OP_FLUSH, $urandom);
            end else begin
                send_request(OP_UNUSED, $urandom);
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
            shadow_tag[s]   = 32'd0;
            shadow_valid[s] = 1'b0;
            shadow_dirty[s] = 1'b0;
        end
        for (int p = 0; p < POOL_SIZE; p++) begin
            id_pool[p] = $urandom;
        end
        id_pool[0] = 32'h0000_0000;
        id_pool[1] = 32'hFFFF_FFFF;

        // hold reset low from the start, then release it on a clock edge
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_lookup_basics();
        test_all_slots_dirty();
        test_random_traffic(120);

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
